// ===== rtl/dqfo_pkg.sv =====
// Package: widths, register codes and sigmoid table arithmetic for the duration quantizer.
`default_nettype none

package dqfo_pkg;

	// Field and state widths
	localparam int LOGIT_W    = 16;
	localparam int DUR_W      = 8;
	localparam int FRAME_W    = 20;
	localparam int SUM_W      = 23;
	localparam int SIG_W      = 16;
	localparam int SPEED_W    = 16;
	localparam int TPP_W      = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Parameter defaults
	localparam int MAX_TERMS_DEF = 64;
	localparam int LUT_BITS_DEF  = 10;

	// Table covers logits in [-16,16): 13 bits of Q8.8 offset range
	localparam int LUT_SPAN_BITS = 13;
	localparam int LOGIT_LO      = -4096;
	localparam int LOGIT_HI      = 4095;

	// Q4.12 times Q0.16 gives a Q.28 product
	localparam int ROUND_POS = 28;

	// Register reset values
	localparam logic [SPEED_W-1:0] INV_SPEED_RST = 16'd4096;
	localparam logic [TPP_W-1:0]   TPP_RST       = 7'd50;

	// Saturation limits
	localparam logic [DUR_W-1:0]   DUR_MAX   = '1;
	localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_SPEED = 0,
		CFG_TERMS     = 1
	} cfg_reg_t;

	localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

	// Shift-subtract divide, evaluated only while the table is built
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid of sx * 2^-9 as rounded Q0.16; exp(-|x|) from a short series
	// of exp(-|x|/256) squared eight times, all in Q0.31
	function automatic logic [SIG_W-1:0] sigmoid_q16(input int sx);
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] r2;
		logic [63:0] r3;
		logic [63:0] r4;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		t  = (sx < 0) ? 64'(-sx) : 64'(sx);
		r  = t << 14;
		r2 = (r * r) >> 31;
		r3 = (r2 * r) >> 31;
		r4 = (r3 * r) >> 31;
		e  = Q31_ONE - r + r2 / 64'd2 - r3 / 64'd6 + r4 / 64'd24;
		for (int k = 0; k < 8; k++) begin
			e = (e * e) >> 31;
		end
		den = Q31_ONE + e;
		num = (sx >= 0) ? (Q31_ONE << 16) : (e << 16);
		q   = udiv64(num + (den >> 1), den);
		if (q > 64'd65535) begin
			q = 64'd65535;
		end
		return q[SIG_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dqfo_intf.sv =====
// Interfaces: logit input channel, duration result channel, configuration write channel.
`default_nettype none

interface dqfo_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dqfo_pkg::LOGIT_W-1:0]   logit;
	logic                                  end_of_utterance;

	modport source (output valid, output logit, output end_of_utterance, input ready);
	modport sink   (input valid, input logit, input end_of_utterance, output ready);
endinterface

interface dqfo_out_if;
	logic                            valid;
	logic                            ready;
	logic [dqfo_pkg::DUR_W-1:0]      duration;
	logic [dqfo_pkg::FRAME_W-1:0]    start_frame;
	logic                            saturated;

	modport source (output valid, output duration, output start_frame, output saturated,
		input ready);
	modport sink   (input valid, input duration, input start_frame, input saturated,
		output ready);
endinterface

interface dqfo_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [dqfo_pkg::CFG_IDX_W-1:0]    index;
	logic [dqfo_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dqfo_sigmoid_lut.sv =====
// Sigmoid lookup: logit clamp, table index and registered read of the constant table.
`default_nettype none

module dqfo_sigmoid_lut #(
	parameter int LUT_BITS = dqfo_pkg::LUT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [dqfo_pkg::LOGIT_W-1:0] logit,
	output      logic [dqfo_pkg::SIG_W-1:0]          sig
);

	localparam int LUT_SIZE = 1 << LUT_BITS;
	localparam int SPAN     = dqfo_pkg::LUT_SPAN_BITS;
	// bin width in units of 2^-9
	localparam int W        = 16384 >> LUT_BITS;

	typedef logic [dqfo_pkg::SIG_W-1:0] lut_arr_t [LUT_SIZE];

	// entry i sits at the center of its bin
	function automatic lut_arr_t build_lut();
		lut_arr_t a;
		for (int i = 0; i < LUT_SIZE; i++) begin
			a[i] = dqfo_pkg::sigmoid_q16(i * W + W / 2 - 8192);
		end
		return a;
	endfunction

	localparam lut_arr_t LUT = build_lut();

	logic [SPAN-1:0]          ofs;
	logic [SPAN+LUT_BITS-1:0] ofs_sh;
	logic [LUT_BITS-1:0]      idx;

	// clamp to the table range and take the top bits of the offset
	always_comb begin
		if (logit < 16'(dqfo_pkg::LOGIT_LO)) begin
			ofs = '0;
		end else if (logit > 16'(dqfo_pkg::LOGIT_HI)) begin
			ofs = '1;
		end else begin
			ofs = SPAN'(logit - 16'(dqfo_pkg::LOGIT_LO));
		end
		ofs_sh = {ofs, {LUT_BITS{1'b0}}};
		idx    = ofs_sh[SPAN+LUT_BITS-1:SPAN];
	end

	// registered table read, held while the next stage stalls
	always_ff @(posedge clk) begin
		if (en) begin
			sig <= LUT[idx];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/duration_quantizer_frame_offsets_core.sv =====
// Duration quantizer top level: sigmoid sum per phoneme, speed scaling, frame offsets.
// Pipeline: four register stages (table read, accumulate, multiply, round/offset)
//   lie between accepting a phoneme's last logit and its result; one logit per cycle
//   is taken unless the output stalls; the 23x16 speed multiply sits in its own stage.
// Reset (arst_n low, asynchronous): pipeline empties, term count, sigmoid sum and
//   frame total clear, inv_speed returns to 1.0 and terms_per_phoneme to 50.
`default_nettype none

module duration_quantizer_frame_offsets_core #(
	parameter int MAX_TERMS        = dqfo_pkg::MAX_TERMS_DEF,
	parameter int SIGMOID_LUT_BITS = dqfo_pkg::LUT_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dqfo_cfg_if.sink   cfg,
	dqfo_in_if.sink    logits,
	dqfo_out_if.source durations
);

	localparam int SUM_W   = dqfo_pkg::SUM_W;
	localparam int SIG_W   = dqfo_pkg::SIG_W;
	localparam int SPEED_W = dqfo_pkg::SPEED_W;
	localparam int TPP_W   = dqfo_pkg::TPP_W;
	localparam int DUR_W   = dqfo_pkg::DUR_W;
	localparam int FRAME_W = dqfo_pkg::FRAME_W;
	localparam int CNT_W   = $clog2(MAX_TERMS + 1);
	localparam int CMP_W   = ((CNT_W > TPP_W) ? CNT_W : TPP_W) + 1;
	localparam int PROD_W  = SUM_W + SPEED_W;
	localparam int RPOS    = dqfo_pkg::ROUND_POS;
	localparam int RW      = PROD_W - RPOS + 1;

	// configuration registers
	logic [SPEED_W-1:0] inv_speed_q;
	logic [TPP_W-1:0]   terms_q;

	// stage enables
	logic en1, en2, en3, en4;

	// stage 1: table read
	logic             v1;
	logic             eou_s1;
	logic [SIG_W-1:0] sig_s1;

	// stage 2: accumulate
	logic             v2;
	logic             eou_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [CMP_W-1:0] tpp_ext;
	logic [CMP_W-1:0] n_eff;
	logic             last;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_sat;

	// stage 3: speed multiply
	logic              v3;
	logic              eou_s3;
	logic [PROD_W-1:0] prod_s3;

	// stage 4: round, clamp, frame offset
	logic               out_v_q;
	logic [DUR_W-1:0]   dur_q;
	logic [FRAME_W-1:0] start_q;
	logic               sat_q;
	logic [FRAME_W-1:0] frame_q;
	logic [RW:0]        rsum;
	logic [RW-1:0]      rnd;
	logic [DUR_W-1:0]   dur_c;
	logic               dur_sat;
	logic [FRAME_W:0]   ft_sum;
	logic               ft_ovf;

	// configuration writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_speed_q <= dqfo_pkg::INV_SPEED_RST;
			terms_q     <= dqfo_pkg::TPP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				dqfo_pkg::CFG_INV_SPEED: inv_speed_q <= cfg.data[SPEED_W-1:0];
				dqfo_pkg::CFG_TERMS:     terms_q     <= cfg.data[TPP_W-1:0];
				default: ;
			endcase
		end
	end

	// each stage moves when it is empty or the next one moves
	assign en4          = !out_v_q || durations.ready;
	assign en3          = !v3 || en4;
	assign en2          = !v2 || en3;
	assign en1          = !v1 || en2;
	assign logits.ready = en1;

	// stage 1
	dqfo_sigmoid_lut #(
		.LUT_BITS(SIGMOID_LUT_BITS)
	) u_lut (
		.clk  (clk),
		.en   (en1),
		.logit(logits.logit),
		.sig  (sig_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
		end else if (en1) begin
			v1 <= logits.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			eou_s1 <= logits.end_of_utterance;
		end
	end

	// stage 2: effective count is terms_per_phoneme bounded to 1..MAX_TERMS
	always_comb begin
		tpp_ext = CMP_W'(terms_q);
		if (tpp_ext == '0) begin
			n_eff = CMP_W'(1);
		end else if (tpp_ext > CMP_W'(MAX_TERMS)) begin
			n_eff = CMP_W'(MAX_TERMS);
		end else begin
			n_eff = tpp_ext;
		end
		last    = (CMP_W'(count_q) + CMP_W'(1)) >= n_eff;
		sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sig_s1);
		sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2      <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (en2) begin
			v2 <= v1 && last;
			if (v1) begin
				if (last) begin
					count_q <= '0;
					sum_q   <= '0;
				end else begin
					count_q <= count_q + CNT_W'(1);
					sum_q   <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1 && last) begin
			sum_s2 <= sum_sat;
			eou_s2 <= eou_s1;
		end
	end

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3 <= 1'b0;
		end else if (en3) begin
			v3 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(inv_speed_q);
			eou_s3  <= eou_s2;
		end
	end

	// stage 4: round half up to frames, clamp to 1..255, advance frame total or clear it at end of utterance
	always_comb begin
		rsum = {1'b0, prod_s3[PROD_W-1:RPOS-1]} + (RW + 1)'(1);
		rnd  = rsum[RW:1];
		dur_sat = 1'b0;
		if (rnd == '0) begin
			dur_c = DUR_W'(1);
		end else if (rnd > RW'(dqfo_pkg::DUR_MAX)) begin
			dur_c   = dqfo_pkg::DUR_MAX;
			dur_sat = 1'b1;
		end else begin
			dur_c = rnd[DUR_W-1:0];
		end
		ft_sum = {1'b0, frame_q} + (FRAME_W + 1)'(dur_c);
		ft_ovf = ft_sum > {1'b0, dqfo_pkg::FRAME_MAX};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			frame_q <= '0;
		end else if (en4) begin
			out_v_q <= v3;
			if (v3) begin
				if (eou_s3) begin
					frame_q <= '0;
				end else if (ft_ovf) begin
					frame_q <= dqfo_pkg::FRAME_MAX;
				end else begin
					frame_q <= ft_sum[FRAME_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v3) begin
			dur_q   <= dur_c;
			start_q <= frame_q;
			sat_q   <= dur_sat || ft_ovf;
		end
	end

	assign durations.valid       = out_v_q;
	assign durations.duration    = dur_q;
	assign durations.start_frame = start_q;
	assign durations.saturated   = sat_q;

endmodule

`default_nettype wire

// ===== rtl/dqfo_checker.sv =====
// Port-level checker for the duration quantizer, bound to the top level.
`default_nettype none

module dqfo_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [dqfo_pkg::DUR_W-1:0]     duration,
	input wire logic [dqfo_pkg::FRAME_W-1:0]   start_frame,
	input wire logic                           saturated,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready
);

	// no result shows while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duration)
			&& $stable(start_frame) && $stable(saturated))
		else $error("stalled result changed");

	// duration is clamped below at one frame
	a_dur_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duration != '0)
		else $error("zero duration");

	// a logit offered while the output side is empty is taken
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind duration_quantizer_frame_offsets_core dqfo_checker u_dqfo_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (logits.valid),
	.in_ready   (logits.ready),
	.out_valid  (durations.valid),
	.out_ready  (durations.ready),
	.duration   (durations.duration),
	.start_frame(durations.start_frame),
	.saturated  (durations.saturated),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);

`default_nettype wire
